// ===== rtl/core/hrrn_pkg.sv =====
// hrrn_pkg: shared types, constants and codes for the hrrn ready-queue scheduler
// no dependencies
package hrrn_pkg;

	localparam int MaxProcsDef = 16;
	localparam int IdW = 4;
	localparam int SvcW = 16;
	localparam int TickW = 32;
	localparam int SliceW = 14;
	localparam int CntW = 5;
	localparam int CfgW = 8;
	localparam logic [CfgW-1:0] BaseSliceRst = 8'd5;
	localparam int SliceMult = 50;

	typedef enum logic [1:0] {
		FUNC_ENQ  = 2'd0,
		FUNC_DEQ  = 2'd1,
		FUNC_PICK = 2'd2,
		FUNC_TICK = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]      func;
		logic [IdW-1:0]  proc_id;
		logic [SvcW-1:0] svc_time;
	} in_item_t;

	typedef struct packed {
		logic            pick_valid;
		logic [IdW-1:0]  picked_id;
		logic            resched_req;
		logic            status;
		logic [CntW-1:0] queued_count;
	} out_item_t;

	// one slot's view, handed along the ring of cells
	typedef struct packed {
		logic             valid;
		logic [TickW-1:0] entry;
		logic [SvcW-1:0]  svc;
	} slot_view_t;

	// per-cycle control from top to cells
	typedef struct packed {
		logic            enq;
		logic            deq;
		logic            tick;
		logic            rotate;
		logic [SvcW-1:0] svc;
		logic [TickW-1:0] now;
		logic [SliceW-1:0] slice;
	} cell_ctl_t;

endpackage

// ===== rtl/core/hrrn_cell.sv =====
// hrrn_cell: one process slot of the ring; holds valid, entry tick, service, slice
// depends on hrrn_pkg
module hrrn_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                is_slot,
	input  hrrn_pkg::cell_ctl_t ctl,
	input  hrrn_pkg::slot_view_t prev,
	output hrrn_pkg::slot_view_t view,
	output logic                valid_now,
	output logic                resched
);
	import hrrn_pkg::*;

	logic              valid_q;
	logic [TickW-1:0]  entry_q;
	logic [SvcW-1:0]   svc_q;
	logic [SliceW-1:0] slice_q;
	logic [SliceW-1:0] slice_dec;

	assign slice_dec = (slice_q != '0) ? slice_q - SliceW'(1) : slice_q;
	assign resched   = (slice_dec == '0);
	assign view      = '{valid: valid_q, entry: entry_q, svc: svc_q};
	assign valid_now = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slice_q <= '0;
		end else if (ctl.rotate) begin
			valid_q <= prev.valid;
		end else if (is_slot) begin
			if (ctl.enq && !valid_q) begin
				valid_q <= 1'b1;
				slice_q <= ctl.slice;
			end else if (ctl.deq) begin
				valid_q <= 1'b0;
			end else if (ctl.tick) begin
				slice_q <= slice_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			entry_q <= prev.entry;
			svc_q   <= prev.svc;
		end else if (is_slot && ctl.enq && !valid_q) begin
			entry_q <= ctl.now;
			svc_q   <= (ctl.svc == '0) ? SvcW'(1) : ctl.svc;
		end
	end

endmodule

// ===== rtl/core/hrrn_judge.sv =====
// hrrn_judge: compares the slot at the ring head against the best so far
// two-stage: products registered, then compare and update; depends on hrrn_pkg
module hrrn_judge #(
	parameter int MaxProcs = hrrn_pkg::MaxProcsDef,
	parameter int IdxW = $clog2(MaxProcs)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 step,
	input  logic [IdxW-1:0]      idx,
	input  logic [hrrn_pkg::TickW-1:0] now,
	input  hrrn_pkg::slot_view_t head,
	output logic                 found,
	output logic [IdxW-1:0]      best_idx
);
	import hrrn_pkg::*;

	localparam int WW = TickW + 1;
	localparam int PW = WW + SvcW;

	logic [TickW-1:0] bwait_q;
	logic [SvcW-1:0]  bsvc_q;
	logic             found_q;
	logic [IdxW-1:0]  bidx_q;

	logic             v_s1;
	logic [IdxW-1:0]  idx_s1;
	logic [TickW-1:0] wait_s1;
	logic [SvcW-1:0]  svc_s1;
	logic [PW-1:0]    lhs_s1, rhs_s1;
	logic [TickW-1:0] cwait;
	logic             beats;

	assign cwait = now - head.entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= step && head.valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		wait_s1 <= cwait;
		svc_s1  <= head.svc;
		lhs_s1  <= PW'(WW'(cwait) + WW'(head.svc)) * PW'(bsvc_q);
		rhs_s1  <= PW'(WW'(bwait_q) + WW'(bsvc_q)) * PW'(head.svc);
	end

	always_comb begin
		if (lhs_s1 != rhs_s1)      beats = lhs_s1 > rhs_s1;
		else if (svc_s1 != bsvc_q) beats = svc_s1 < bsvc_q;
		else if (wait_s1 != bwait_q) beats = wait_s1 > bwait_q;
		else                       beats = 1'b0;
	end

	// a step only follows the previous step's update, so best is stable at s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			bidx_q  <= '0;
		end else if (start) begin
			found_q <= 1'b0;
			bidx_q  <= '0;
		end else if (v_s1 && (!found_q || beats)) begin
			found_q <= 1'b1;
			bidx_q  <= idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && (!found_q || beats)) begin
			bwait_q <= wait_s1;
			bsvc_q  <= svc_s1;
		end
	end

	assign found    = found_q;
	assign best_idx = bidx_q;

endmodule

// ===== rtl/core/hrrn_ready_queue_scheduler.sv =====
// hrrn_ready_queue_scheduler: top level, ring of slot cells and a ratio judge
// depends on hrrn_pkg, hrrn_cell, hrrn_judge
//
// channel  dir  handshake      payload
// cfg      in   valid/ready    base_time_slice
// in       in   valid/stall    in_item_t
// out      out  valid/stall    out_item_t
//
// enqueue, dequeue, tick: result registered. pick: scan length set by the ring rotating
// one cell at a time past the single multiply judge.
// reset clears the table, clock, count and slice; base slice resets to 5.
// the output register holds a result until transferred; the next item waits for it.
module hrrn_ready_queue_scheduler #(
	parameter int MaxProcs = hrrn_pkg::MaxProcsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [hrrn_pkg::CfgW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  hrrn_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hrrn_pkg::out_item_t out_data
);
	import hrrn_pkg::*;

	localparam int IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
	localparam int RotW = $clog2(MaxProcs + 1);

	state_t state_q, state_d;
	logic [CfgW-1:0]  base_q;
	logic [TickW-1:0] clock_q;
	logic [CntW-1:0]  count_q;
	in_item_t         item_q;
	logic [RotW-1:0]  rot_q;
	logic             phase_q;
	logic             ovalid_q;
	out_item_t        out_q;
	out_item_t        res_d;

	cell_ctl_t        ctl;
	slot_view_t       views [MaxProcs];
	logic [MaxProcs-1:0] vnow, rs;
	logic             accept, in_range, cur_valid, cur_rs;
	logic [IdxW-1:0]  id_idx, head_idx;
	logic             jfound;
	logic [IdxW-1:0]  jbest;
	logic             step, start, rotate;
	logic [SliceW-1:0] slice_val;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign cfg_ready = 1'b1;
	assign in_range = 32'(in_data.proc_id) < MaxProcs;
	assign id_idx   = IdxW'(in_data.proc_id);
	assign cur_valid = in_range && vnow[id_idx];
	assign cur_rs    = !in_range || rs[id_idx];
	assign slice_val = SliceW'(32'(base_q) * SliceMult);
	assign head_idx  = IdxW'(rot_q);

	assign start  = accept && (func_t'(in_data.func) == FUNC_PICK);
	assign step   = (state_q == ST_SCAN) && !phase_q && (rot_q < RotW'(MaxProcs));
	assign rotate = (state_q == ST_SCAN) && phase_q;

	always_comb begin
		ctl.enq    = accept && func_t'(in_data.func) == FUNC_ENQ;
		ctl.deq    = accept && func_t'(in_data.func) == FUNC_DEQ;
		ctl.tick   = accept && func_t'(in_data.func) == FUNC_TICK;
		ctl.rotate = rotate;
		ctl.svc    = in_data.svc_time;
		ctl.now    = clock_q;
		ctl.slice  = slice_val;
	end

	for (genvar g = 0; g < MaxProcs; g++) begin : g_cell
		hrrn_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.is_slot(in_range && id_idx == IdxW'(g)),
			.ctl(ctl),
			.prev(views[(g + 1) % MaxProcs]),
			.view(views[g]),
			.valid_now(vnow[g]),
			.resched(rs[g])
		);
	end

	hrrn_judge #(.MaxProcs(MaxProcs), .IdxW(IdxW)) u_judge (
		.clk(clk), .arst_n(arst_n), .start(start), .step(step),
		.idx(head_idx), .now(clock_q), .head(views[0]),
		.found(jfound), .best_idx(jbest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (rotate && rot_q == RotW'(MaxProcs - 1)) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BaseSliceRst;
			clock_q  <= '0;
			count_q  <= '0;
			rot_q    <= '0;
			phase_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) base_q <= cfg_data;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (start) begin
				rot_q   <= '0;
				phase_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				phase_q <= !phase_q;
				if (rotate) rot_q <= rot_q + RotW'(1);
			end
			if (accept && func_t'(in_data.func) != FUNC_PICK) begin
				ovalid_q <= 1'b1;
				case (func_t'(in_data.func))
					FUNC_ENQ:  if (in_range && !cur_valid) count_q <= count_q + CntW'(1);
					FUNC_DEQ:  if (cur_valid) count_q <= count_q - CntW'(1);
					FUNC_TICK: clock_q <= clock_q + TickW'(1);
					default:   ;
				endcase
			end
			if (state_q == ST_DONE) ovalid_q <= 1'b1;
		end
	end

	always_comb begin
		res_d = '0;
		res_d.queued_count = count_q;
		case (func_t'(in_data.func))
			FUNC_ENQ: begin
				res_d.status = !in_range || cur_valid;
				res_d.queued_count = count_q + CntW'(in_range && !cur_valid);
			end
			FUNC_DEQ: begin
				res_d.status = !cur_valid;
				res_d.queued_count = count_q - CntW'(cur_valid);
			end
			FUNC_TICK: res_d.resched_req = cur_rs;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_data;
		if (accept) begin
			out_q <= res_d;
		end else if (state_q == ST_DONE) begin
			out_q.pick_valid <= jfound;
			out_q.picked_id  <= jfound ? IdW'(jbest) : '0;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxProcs)) else $error("count overflow");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("pick result lost");
	a_pick_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> func_t'(item_q.func) == FUNC_PICK)
		else $error("scan without pick");
`endif

endmodule
